>>> hdl/lfrs_pkg.sv
`default_nettype none

package lfrs_pkg;

  localparam int LagDepth  = 55;
  localparam int TrailTap  = 55 - 24;
  localparam int WordW     = 30;
  localparam int DrawShift = 6;
  localparam int DrawW     = WordW - DrawShift;
  localparam int DataW     = 32;
  localparam int SpanW     = DataW + 2;
  localparam int DoorW     = 4;
  localparam int DoorMax   = 9;
  localparam int DoorTries = 4096;
  localparam int DoorCntW  = $clog2(DoorTries);
  localparam int FillCntW  = $clog2(LagDepth);
  localparam int ModCntW   = $clog2(DrawW);

  typedef enum logic [1:0] {
    REQ_RANGE,
    REQ_BITS,
    REQ_DOOR,
    REQ_NONE
  } req_e;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

`default_nettype wire

>>> hdl/lfrs_cell.sv
`default_nettype none

module lfrs_cell (
  input  wire logic                       clk_i,
  input  wire logic                       shift_i,
  input  wire logic [lfrs_pkg::WordW-1:0] d_i,
  output logic      [lfrs_pkg::WordW-1:0] q_o
);

  logic [lfrs_pkg::WordW-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

`default_nettype wire

>>> hdl/lfrs_mod.sv
`default_nettype none

module lfrs_mod (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lfrs_pkg::DrawW-1:0] dividend_i,
  input  wire logic [lfrs_pkg::DrawW:0]   divisor_i,
  output lfrs_pkg::mod_stat_t             stat_o,
  output logic      [lfrs_pkg::DrawW-1:0] rem_o
);

  logic [lfrs_pkg::DrawW-1:0]   rem_q, rem_d;
  logic [lfrs_pkg::DrawW-1:0]   dvd_q, dvd_d;
  logic [lfrs_pkg::DrawW:0]     div_q, div_d;
  logic [lfrs_pkg::ModCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [lfrs_pkg::DrawW:0]     trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_q, dvd_q[lfrs_pkg::DrawW-1]};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = lfrs_pkg::ModCntW'(lfrs_pkg::DrawW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (trial >= div_q) ? lfrs_pkg::DrawW'(trial - div_q)
                               : trial[lfrs_pkg::DrawW-1:0];
      dvd_d = {dvd_q[lfrs_pkg::DrawW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

>>> hdl/lagged_fibonacci_random_source.sv
// channel   handshake               beat
// input     in_valid_i / in_stall_o  req_type_i, range_low_i, range_high_i, bit_width_i
// output    out_valid_o / out_stall_i drawn_value_o
// config    cfg_we_i                 cfg_wdata_i (seed)
//
// one request at a time; a bit draw, an empty range or an unused type passes EXEC and DONE
// on its way to the result, a range draw also passes MOD (24-step serial remainder unit)
// a door draw stays in EXEC for each retry, one table step each
// after reset and after each seed write the 55-cell ring refills,
// with in_stall_o high
// a finished result waits in the output register while the next beat is accepted

`default_nettype none

module lagged_fibonacci_random_source (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [lfrs_pkg::WordW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [31:0]                range_low_i,
  input  wire logic [31:0]                range_high_i,
  input  wire logic [4:0]                 bit_width_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [31:0]                drawn_value_o
);

  localparam int W  = lfrs_pkg::WordW;
  localparam int DW = lfrs_pkg::DataW;
  localparam int RW = lfrs_pkg::DrawW;
  localparam int SW = lfrs_pkg::SpanW;

  lfrs_pkg::state_e state_q, state_d;

  logic [W-1:0]                    seed_q;
  logic [lfrs_pkg::FillCntW-1:0]   fill_cnt_q, fill_cnt_d;
  logic [lfrs_pkg::DoorCntW-1:0]   door_cnt_q, door_cnt_d;
  lfrs_pkg::req_e                  req_q;
  logic [DW-1:0]                   lo_q, hi_q;
  logic [4:0]                      bw_q;
  logic [DW-1:0]                   res_q, res_d;
  logic                            out_valid_q, out_valid_d;
  logic [DW-1:0]                   drawn_q, drawn_d;

  logic [W-1:0]  cell_q [lfrs_pkg::LagDepth];
  logic [W-1:0]  sum, fill_val, feed;
  logic          shift, draw, mod_start, accept, load;
  logic [RW-1:0] raw;

  logic [SW-1:0]               span;
  logic                        span_le1, span_big;
  logic [RW:0]                 divisor;
  logic [DW-1:0]               bit_mask, bits_res;
  logic [lfrs_pkg::DoorW-1:0]  door_digit;
  logic                        door_ok, door_last;
  lfrs_pkg::mod_stat_t         mod_stat;
  logic [RW-1:0]               mod_rem;

  // ring of lag cells, cell 0 holds the lead entry
  for (genvar i = 0; i < lfrs_pkg::LagDepth; i++) begin : g_ring
    if (i == lfrs_pkg::LagDepth - 1) begin : g_tail
      lfrs_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .d_i     (feed),
        .q_o     (cell_q[i])
      );
    end else begin : g_body
      lfrs_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .d_i     (cell_q[i+1]),
        .q_o     (cell_q[i])
      );
    end
  end

  assign sum = cell_q[0] + cell_q[lfrs_pkg::TrailTap];
  assign raw = sum[W-1:lfrs_pkg::DrawShift];

  always_comb begin
    if (fill_cnt_q == '0) begin
      fill_val = seed_q;
    end else if (fill_cnt_q == lfrs_pkg::FillCntW'(1)) begin
      fill_val = W'(1);
    end else begin
      fill_val = cell_q[lfrs_pkg::LagDepth-1] + cell_q[lfrs_pkg::LagDepth-2];
    end
  end

  assign feed  = (state_q == lfrs_pkg::ST_FILL) ? fill_val : sum;
  assign shift = (state_q == lfrs_pkg::ST_FILL) || draw;

  assign in_stall_o = (state_q != lfrs_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = (state_q == lfrs_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  // request decode
  assign span     = {{2{hi_q[DW-1]}}, hi_q} - {{2{lo_q[DW-1]}}, lo_q} + SW'(1);
  assign span_le1 = ($signed(span) <= $signed(SW'(1)));
  assign span_big = |span[SW-1:RW];
  assign divisor  = span_big ? ((RW+1)'(1) << RW) : span[RW:0];

  assign bit_mask = ~({DW{1'b1}} << bw_q);
  assign bits_res = {{(DW-RW){1'b0}}, raw} & bit_mask;

  assign door_digit = raw[lfrs_pkg::DoorW-1:0];
  assign door_ok    = (door_digit <= lfrs_pkg::DoorW'(lfrs_pkg::DoorMax));
  assign door_last  = (door_cnt_q == lfrs_pkg::DoorCntW'(lfrs_pkg::DoorTries - 1));

  lfrs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (raw),
    .divisor_i  (divisor),
    .stat_o     (mod_stat),
    .rem_o      (mod_rem)
  );

  // next state
  always_comb begin
    state_d    = state_q;
    fill_cnt_d = fill_cnt_q;
    case (state_q)
      lfrs_pkg::ST_FILL: begin
        fill_cnt_d = fill_cnt_q + 1'b1;
        if (fill_cnt_q == lfrs_pkg::FillCntW'(lfrs_pkg::LagDepth - 1)) begin
          state_d = lfrs_pkg::ST_IDLE;
        end
      end
      lfrs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lfrs_pkg::ST_EXEC;
        end
      end
      lfrs_pkg::ST_EXEC: begin
        case (req_q)
          lfrs_pkg::REQ_RANGE: state_d = span_le1 ? lfrs_pkg::ST_DONE : lfrs_pkg::ST_MOD;
          lfrs_pkg::REQ_DOOR: begin
            if (door_ok || door_last) begin
              state_d = lfrs_pkg::ST_DONE;
            end
          end
          default: state_d = lfrs_pkg::ST_DONE;
        endcase
      end
      lfrs_pkg::ST_MOD: begin
        if (mod_stat.done) begin
          state_d = lfrs_pkg::ST_DONE;
        end
      end
      lfrs_pkg::ST_DONE: begin
        if (load) begin
          state_d = lfrs_pkg::ST_IDLE;
        end
      end
      default: state_d = lfrs_pkg::ST_FILL;
    endcase
    if (cfg_we_i) begin
      state_d    = lfrs_pkg::ST_FILL;
      fill_cnt_d = '0;
    end
  end

  // datapath controls and result
  always_comb begin
    draw        = 1'b0;
    mod_start   = 1'b0;
    res_d       = res_q;
    door_cnt_d  = door_cnt_q;
    out_valid_d = out_valid_q;
    drawn_d     = drawn_q;
    case (state_q)
      lfrs_pkg::ST_IDLE: begin
        door_cnt_d = '0;
      end
      lfrs_pkg::ST_EXEC: begin
        case (req_q)
          lfrs_pkg::REQ_RANGE: begin
            if (span_le1) begin
              res_d = lo_q;
            end else begin
              draw      = 1'b1;
              mod_start = 1'b1;
            end
          end
          lfrs_pkg::REQ_BITS: begin
            draw  = 1'b1;
            res_d = bits_res;
          end
          lfrs_pkg::REQ_DOOR: begin
            draw       = 1'b1;
            door_cnt_d = door_cnt_q + 1'b1;
            res_d      = door_ok ? {{(DW-lfrs_pkg::DoorW){1'b0}}, door_digit}
                                 : DW'(lfrs_pkg::DoorMax);
          end
          default: res_d = '0;
        endcase
      end
      lfrs_pkg::ST_MOD: begin
        if (mod_stat.done) begin
          res_d = lo_q + {{(DW-RW){1'b0}}, mod_rem};
        end
      end
      default: ;
    endcase
    if (load) begin
      out_valid_d = 1'b1;
      drawn_d     = res_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfrs_pkg::ST_FILL;
      fill_cnt_q  <= '0;
      seed_q      <= W'(1);
      out_valid_q <= 1'b0;
      door_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      fill_cnt_q  <= fill_cnt_d;
      out_valid_q <= out_valid_d;
      door_cnt_q  <= door_cnt_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= lfrs_pkg::req_e'(req_type_i);
      lo_q  <= range_low_i;
      hi_q  <= range_high_i;
      bw_q  <= bit_width_i;
    end
    res_q   <= res_d;
    drawn_q <= drawn_d;
  end

  assign out_valid_o   = out_valid_q;
  assign drawn_value_o = drawn_q;

endmodule

`default_nettype wire

>>> hdl/lfrs_checker.sv
`default_nettype none

module lfrs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] drawn_value_o
);

  // a seed write starts a refill, so no beat is taken next cycle
  a_cfg_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input open right after seed write");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(drawn_value_o))
    else $error("stalled result changed");

endmodule

bind lagged_fibonacci_random_source lfrs_checker u_lfrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drawn_value_o (drawn_value_o)
);

`default_nettype wire

>>> test/lagged_fibonacci_random_source_tb.sv
`timescale 1ns / 1ps

module lagged_fibonacci_random_source_tb;

  typedef struct {
    lfrs_pkg::req_e kind;
    logic [31:0]    lo;
    logic [31:0]    hi;
    logic [4:0]     width;
  } draw_req_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [lfrs_pkg::WordW-1:0] cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 req_type_i;
  logic [31:0]                range_low_i;
  logic [31:0]                range_high_i;
  logic [4:0]                 bit_width_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [31:0]                drawn_value_o;

  lagged_fibonacci_random_source dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .bit_width_i   (bit_width_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drawn_value_o (drawn_value_o)
  );

  // generator state mirror
  logic [lfrs_pkg::WordW-1:0] lag_ring [lfrs_pkg::LagDepth];
  int unsigned                head_idx;
  int unsigned                tail_idx;

  draw_req_t   pending_reqs [$];
  logic [31:0] expected_draws [$];
  logic [31:0] want_draw;
  logic        beat_taken = 1'b0;
  bit          gaps_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_gap = 0;
  int          fail_count = 0;

  function void reseed_ring(input logic [lfrs_pkg::WordW-1:0] seed);
    lag_ring[0] = seed;
    lag_ring[1] = lfrs_pkg::WordW'(1);
    for (int k = 2; k < lfrs_pkg::LagDepth; k++) lag_ring[k] = lag_ring[k-1] + lag_ring[k-2];
    head_idx = 0;
    tail_idx = lfrs_pkg::TrailTap;
  endfunction

  function logic [lfrs_pkg::DrawW-1:0] next_raw();
    logic [lfrs_pkg::WordW-1:0] sum;
    sum = lag_ring[head_idx] + lag_ring[tail_idx];
    lag_ring[head_idx] = sum;
    head_idx = (head_idx == lfrs_pkg::LagDepth - 1) ? 0 : head_idx + 1;
    tail_idx = (tail_idx == lfrs_pkg::LagDepth - 1) ? 0 : tail_idx + 1;
    return sum[lfrs_pkg::WordW-1:lfrs_pkg::DrawShift];
  endfunction

  function logic [31:0] predict_draw(input draw_req_t r);
    longint                     lo_s;
    longint                     hi_s;
    longint                     span;
    longint                     raw_l;
    logic [lfrs_pkg::DrawW-1:0] raw;
    logic [63:0]                mask;
    logic [31:0]                result;
    result = '0;
    case (r.kind)
      lfrs_pkg::REQ_RANGE: begin
        lo_s = $signed(r.lo);
        hi_s = $signed(r.hi);
        span = hi_s - lo_s + 1;
        if (span <= 1) begin
          result = r.lo;
        end else begin
          raw_l = next_raw();
          result = 32'(lo_s + raw_l % span);
        end
      end
      lfrs_pkg::REQ_BITS: begin
        mask = (64'd1 << r.width) - 64'd1;
        result = {{(32-lfrs_pkg::DrawW){1'b0}}, next_raw()} & mask[31:0];
      end
      lfrs_pkg::REQ_DOOR: begin
        result = 32'(lfrs_pkg::DoorMax);
        for (int t = 0; t < lfrs_pkg::DoorTries; t++) begin
          raw = next_raw();
          if (raw[lfrs_pkg::DoorW-1:0] <= lfrs_pkg::DoorMax) begin
            result = {{(32-lfrs_pkg::DoorW){1'b0}}, raw[lfrs_pkg::DoorW-1:0]};
            break;
          end
        end
      end
      default: result = '0;
    endcase
    return result;
  endfunction

  function int unsigned pick_idle();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_req(input lfrs_pkg::req_e kind, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [4:0] width);
    draw_req_t item;
    item.kind = kind;
    item.lo = lo;
    item.hi = hi;
    item.width = width;
    pending_reqs.push_back(item);
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_draws.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic load_seed(input logic [lfrs_pkg::WordW-1:0] seed);
    settle();
    cfg_wdata_i <= seed;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request driver and result-side stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || beat_taken) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          draw_req_t nxt;
          nxt = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= nxt.kind;
          range_low_i <= nxt.lo;
          range_high_i <= nxt.hi;
          bit_width_i <= nxt.width;
          send_gap = pick_idle();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_gap != 0) begin
        out_stall_i <= 1'b1;
        stall_gap--;
      end else begin
        stall_gap = pick_idle();
        out_stall_i <= (stall_gap != 0);
        if (stall_gap != 0) stall_gap--;
      end
    end
  end

  // monitor: result check first, then prediction of the newly accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) reseed_ring(cfg_wdata_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_draws.size() == 0) begin
          $error("drawn_value: unexpected result %0d", $signed(drawn_value_o));
          fail_count++;
        end else begin
          want_draw = expected_draws.pop_front();
          if (drawn_value_o !== want_draw) begin
            $error("drawn_value: expected %0d, actual %0d", $signed(want_draw),
                   $signed(drawn_value_o));
            fail_count++;
          end
        end
      end
      beat_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        expected_draws.push_back(predict_draw('{lfrs_pkg::req_e'(req_type_i), range_low_i,
                                                range_high_i, bit_width_i}));
    end
  end

  initial begin
    draw_req_t                  item;
    int unsigned                pick;
    logic [lfrs_pkg::WordW-1:0] seed_list [6];

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    range_low_i = '0;
    range_high_i = '0;
    bit_width_i = '0;
    out_stall_i = 1'b0;
    reseed_ring(30'd1);

    seed_list[0] = 30'h0;
    seed_list[1] = 30'h3FFF_FFFF;
    seed_list[2] = lfrs_pkg::WordW'($urandom);
    seed_list[3] = 30'd1;
    seed_list[4] = lfrs_pkg::WordW'($urandom);
    seed_list[5] = 30'h2AAA_AAAA;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 7; p++) begin
      if (p != 0) load_seed(seed_list[p-1]);
      gaps_on = (p != 3);
      if (p == 0) begin
        // empty and single-value ranges
        queue_req(lfrs_pkg::REQ_RANGE, 5, 5, 0);
        queue_req(lfrs_pkg::REQ_RANGE, 10, -10, 0);
        queue_req(lfrs_pkg::REQ_RANGE, 32'h8000_0000, 32'h8000_0000, 0);
        queue_req(lfrs_pkg::REQ_RANGE, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        // widest span, small spans and spans at the 24-bit draw limit
        queue_req(lfrs_pkg::REQ_RANGE, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        queue_req(lfrs_pkg::REQ_RANGE, 0, 1, 0);
        queue_req(lfrs_pkg::REQ_RANGE, -1, 0, 0);
        queue_req(lfrs_pkg::REQ_RANGE, -10, 10, 0);
        queue_req(lfrs_pkg::REQ_RANGE, 32'h7FFF_FFFA, 32'h7FFF_FFFF, 0);
        queue_req(lfrs_pkg::REQ_RANGE, 0, 32'h00FF_FFFF, 0);
        queue_req(lfrs_pkg::REQ_RANGE, 0, 32'h0100_0000, 0);
        // mask widths: zero, narrow, whole draw and beyond
        queue_req(lfrs_pkg::REQ_BITS, 0, 0, 0);
        queue_req(lfrs_pkg::REQ_BITS, 0, 0, 1);
        queue_req(lfrs_pkg::REQ_BITS, 0, 0, 23);
        queue_req(lfrs_pkg::REQ_BITS, 0, 0, 24);
        queue_req(lfrs_pkg::REQ_BITS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31);
        repeat (5) queue_req(lfrs_pkg::REQ_DOOR, 0, 0, 0);
        queue_req(lfrs_pkg::REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31);
        queue_req(lfrs_pkg::REQ_NONE, 0, 0, 0);
      end
      for (int n = 0; n < 250; n++) begin
        item.lo = $urandom;
        item.hi = $urandom;
        item.width = $urandom_range(0, 31);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          item.kind = lfrs_pkg::REQ_RANGE;
          case ($urandom_range(0, 3))
            1: item.hi = item.lo + $urandom_range(0, 300);
            2: begin
              item.lo = $urandom_range(0, 2000) - 1000;
              item.hi = item.lo + $urandom_range(1 << 23, 1 << 25);
            end
            3: item.hi = item.lo - $urandom_range(0, 5);
            default: ;
          endcase
        end else if (pick < 65) begin
          item.kind = lfrs_pkg::REQ_BITS;
        end else if (pick < 90) begin
          item.kind = lfrs_pkg::REQ_DOOR;
        end else begin
          item.kind = lfrs_pkg::REQ_NONE;
        end
        pending_reqs.push_back(item);
      end
    end

    settle();
    repeat (60) @(negedge clk_i);
    if (expected_draws.size() != 0) begin
      $error("drawn_value: %0d results never arrived", expected_draws.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
hdl/lfrs_pkg.sv
hdl/lfrs_cell.sv
hdl/lfrs_mod.sv
hdl/lagged_fibonacci_random_source.sv
hdl/lfrs_checker.sv
test/lagged_fibonacci_random_source_tb.sv
